>>> design/lpfs_pkg.sv
// ----------------------------------------------------------------------------
// lpfs_pkg: shared types and constants for the led pixel pwm frame streamer
// operation and status codes, register indexes, field widths, reset values
// ----------------------------------------------------------------------------
package lpfs_pkg;

  // field widths
  localparam int PIX_W          = 24;
  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_CNT_W      = 5;
  localparam int DUTY_W         = 16;
  localparam int PERIOD_W       = 16;
  localparam int LED_CNT_W      = 9;
  localparam int CFG_DATA_W     = 16;

  // serial divide-by-three unit: one dividend bit per cycle over {period+1, 0}
  localparam int DIV_W          = DUTY_W + 2;
  localparam int DIV_CNT_W      = 5;

  // last bit position inside one pixel slot group
  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(BITS_PER_PIXEL - 1);

  // register reset values
  localparam logic [PERIOD_W-1:0]  PERIOD_RST    = 16'd89;
  localparam logic [LED_CNT_W-1:0] CHAIN_LEN_RST = 9'd256;

  // duty values that belong to the reset period
  localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = DUTY_W'((int'(PERIOD_RST) + 1) / 3);
  localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = DUTY_W'(((int'(PERIOD_RST) + 1) * 2) / 3);

  // operation codes
  typedef enum logic [1:0] {
    OP_SET_ONE = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_START   = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  // status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2,
    ST_IDLE  = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic {
    CFG_PWM_PERIOD = 1'b0,
    CFG_CHAIN_LEN  = 1'b1
  } cfg_idx_e;

  // write commands to the pixel store
  typedef struct packed {
    logic set_one;
    logic set_all;
  } store_cmd_t;

endpackage

>>> design/lpfs_div3.sv
// ----------------------------------------------------------------------------
// lpfs_div3: bit-serial divide by three of the pwm period
// shifts {period+1, 0} through a 2-bit remainder one bit per cycle; the
// 17-bit quotient prefix is (period+1)/3, the full 18-bit quotient 2*(period+1)/3
// ----------------------------------------------------------------------------
module lpfs_div3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lpfs_pkg::PERIOD_W-1:0] period_i,
  output logic                          busy_o,
  output logic [lpfs_pkg::DUTY_W-1:0]   zero_duty_o,
  output logic [lpfs_pkg::DUTY_W-1:0]   one_duty_o
);
  import lpfs_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  logic                 run_q, run_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     div_q, div_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [1:0]           rem_q, rem_d;
  logic [DUTY_W-1:0]    zero_q, zero_d;
  logic [DUTY_W-1:0]    one_q, one_d;
  logic [2:0]           trial;
  logic                 ge;
  logic [DUTY_W:0]      p1;

  // one restoring step per cycle
  always_comb begin
    p1     = {1'b0, period_i} + (DUTY_W+1)'(1);
    trial  = {rem_q, div_q[DIV_W-1]};
    ge     = (trial >= 3'd3);
    run_d  = run_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    zero_d = zero_q;
    one_d  = one_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      div_d = {p1, 1'b0};
      quo_d = '0;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = ge ? 2'(trial - 3'd3) : trial[1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      div_d = {div_q[DIV_W-2:0], 1'b0};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        run_d  = 1'b0;
        zero_d = quo_d[DUTY_W:1];
        one_d  = quo_d[DUTY_W-1:0];
      end
    end
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      zero_q <= ZERO_DUTY_RST;
      one_q  <= ONE_DUTY_RST;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      zero_q <= zero_d;
      one_q  <= one_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o      = run_q;
  assign zero_duty_o = zero_q;
  assign one_duty_o  = one_q;

endmodule

>>> design/lpfs_store.sv
// ----------------------------------------------------------------------------
// lpfs_store: pixel color memory with fill sequencer
// one write port shared by single writes and the fill sweep, one registered
// read port with write forwarding; the sweep clears the memory after reset
// ----------------------------------------------------------------------------
module lpfs_store #(
  parameter int LED_MAX = 256,
  parameter int AW      = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpfs_pkg::store_cmd_t       cmd_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [lpfs_pkg::PIX_W-1:0] wr_data_i,
  input  logic [AW-1:0]              fill_last_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [lpfs_pkg::PIX_W-1:0] rd_data_o,
  output logic                       busy_o
);
  import lpfs_pkg::*;

  localparam logic [AW-1:0] ADDR_LAST = AW'(LED_MAX - 1);

  logic [PIX_W-1:0] mem_q [LED_MAX];
  logic [PIX_W-1:0] rd_data_q;
  logic             fill_q, fill_d;
  logic [AW-1:0]    fill_addr_q, fill_addr_d;
  logic [AW-1:0]    fill_end_q, fill_end_d;
  logic [PIX_W-1:0] fill_data_q, fill_data_d;
  logic             we;
  logic [AW-1:0]    wa;
  logic [PIX_W-1:0] wd;

  // fill sweep sequencing
  always_comb begin
    fill_d      = fill_q;
    fill_addr_d = fill_addr_q;
    fill_end_d  = fill_end_q;
    fill_data_d = fill_data_q;
    if (fill_q) begin
      fill_addr_d = fill_addr_q + AW'(1);
      if (fill_addr_q == fill_end_q) begin
        fill_d = 1'b0;
      end
    end else if (cmd_i.set_all) begin
      fill_d      = 1'b1;
      fill_addr_d = '0;
      fill_end_d  = fill_last_i;
      fill_data_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 1'b1;
      fill_addr_q <= '0;
      fill_end_q  <= ADDR_LAST;
      fill_data_q <= '0;
    end else begin
      fill_q      <= fill_d;
      fill_addr_q <= fill_addr_d;
      fill_end_q  <= fill_end_d;
      fill_data_q <= fill_data_d;
    end
  end

  // write port select
  assign we = fill_q | cmd_i.set_one;
  assign wa = fill_q ? fill_addr_q : wr_addr_i;
  assign wd = fill_q ? fill_data_q : wr_data_i;

  // memory with registered read, same-cycle write forwarded
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_data_q <= (we && (wa == rd_addr_i)) ? wd : mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = fill_q;

endmodule

>>> design/led_pixel_pwm_frame_streamer_top.sv
// ----------------------------------------------------------------------------
// led_pixel_pwm_frame_streamer_top: led pixel pwm frame streamer
// every accepted command gives its result in the next cycle (done_o)
// set one pixel, start and tick leave busy_o low; set all keeps
//   busy_o high during the fill sweep over the effective chain length
// a pwm_period write runs the serial divider (busy_o high)
// reset: a clearing pass zeroes the store, busy_o high through its write cycles
// ----------------------------------------------------------------------------
module led_pixel_pwm_frame_streamer_top #(
  parameter int LED_MAX     = 256,
  parameter int RESET_SLOTS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      operation_i,
  input  logic [7:0]                      pixel_index_i,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  // result channel
  output logic                            done_o,
  output logic [lpfs_pkg::DUTY_W-1:0]     duty_o,
  output logic                            duty_valid_o,
  output logic                            frame_last_o,
  output logic [1:0]                      status_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [lpfs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lpfs_pkg::*;

  localparam int AW   = (LED_MAX > 1) ? $clog2(LED_MAX) : 1;
  localparam int NW0  = $clog2(LED_MAX + 1);
  localparam int CW   = (NW0 > LED_CNT_W) ? NW0 : LED_CNT_W;
  localparam int SW   = $clog2(LED_MAX * BITS_PER_PIXEL + RESET_SLOTS + 1);
  localparam int SW1  = SW + 1;

  // configuration registers
  logic [PERIOD_W-1:0]  period_q;
  logic [LED_CNT_W-1:0] chain_len_q;
  logic                 cfg_fire;

  // frame state
  logic                 sending_q, sending_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [AW-1:0]        pix_q, pix_d;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;

  // result registers
  logic                 done_q;
  logic [DUTY_W-1:0]    duty_q, duty_d;
  logic                 valid_q, valid_d;
  logic                 last_q, last_d;
  status_e              status_q, status_d;

  // shared signals
  logic                 accept;
  logic                 div_busy;
  logic                 store_busy;
  logic [DUTY_W-1:0]    zero_duty;
  logic [DUTY_W-1:0]    one_duty;
  logic [PIX_W-1:0]     color;
  logic [PIX_W-1:0]     pix_word;
  store_cmd_t           store_cmd;
  logic [CW-1:0]        led_ext;
  logic [CW-1:0]        n_leds;
  logic [CW-1:0]        n_m1;
  logic [CW-1:0]        idx_ext;
  logic                 in_range;
  logic [SW-1:0]        pix_slots;
  logic [SW:0]          total;
  logic [SW:0]          slot_inc;
  logic                 frame_end;
  logic                 in_pixels;
  logic                 cur_bit;

  assign accept      = start_i & ~busy_o;
  assign busy_o      = store_busy | div_busy;
  assign cfg_ready_o = ~div_busy;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RST;
      chain_len_q <= CHAIN_LEN_RST;
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PWM_PERIOD: period_q    <= cfg_data_i[PERIOD_W-1:0];
        CFG_CHAIN_LEN:  chain_len_q <= cfg_data_i[LED_CNT_W-1:0];
        default:        period_q    <= period_q;
      endcase
    end
  end

  // serial duty computation, rerun on every period write
  lpfs_div3 u_div3 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cfg_fire && (cfg_idx_e'(cfg_index_i) == CFG_PWM_PERIOD)),
    .period_i    (cfg_data_i[PERIOD_W-1:0]),
    .busy_o      (div_busy),
    .zero_duty_o (zero_duty),
    .one_duty_o  (one_duty)
  );

  // effective led count and frame length
  assign led_ext   = CW'(chain_len_q);
  assign n_leds    = (led_ext > CW'(LED_MAX)) ? CW'(LED_MAX) : led_ext;
  assign n_m1      = n_leds - CW'(1);
  assign idx_ext   = CW'(pixel_index_i);
  assign in_range  = (idx_ext < n_leds);
  assign pix_slots = (SW'(n_leds) << 4) + (SW'(n_leds) << 3);
  assign total     = {1'b0, pix_slots} + SW1'(RESET_SLOTS);
  assign slot_inc  = {1'b0, slot_q} + SW1'(1);
  assign frame_end = (slot_inc >= total);
  assign in_pixels = (slot_q < pix_slots);
  assign cur_bit   = pix_word[BIT_LAST - bit_q];
  assign color     = {blue_i, green_i, red_i};

  // command decode
  always_comb begin
    sending_d = sending_q;
    slot_d    = slot_q;
    pix_d     = pix_q;
    bit_d     = bit_q;
    duty_d    = '0;
    valid_d   = 1'b0;
    last_d    = 1'b0;
    status_d  = ST_OK;
    store_cmd = '0;
    if (accept) begin
      case (op_e'(operation_i))
        OP_SET_ONE: begin
          if (in_range) begin
            store_cmd.set_one = 1'b1;
          end else begin
            status_d = ST_RANGE;
          end
        end
        OP_SET_ALL: begin
          store_cmd.set_all = (n_leds != '0);
        end
        OP_START: begin
          if (sending_q) begin
            status_d = ST_BUSY;
          end else begin
            sending_d = 1'b1;
            slot_d    = '0;
            pix_d     = '0;
            bit_d     = '0;
          end
        end
        OP_TICK: begin
          if (!sending_q) begin
            status_d = ST_IDLE;
          end else begin
            valid_d = 1'b1;
            if (in_pixels) begin
              duty_d = cur_bit ? one_duty : zero_duty;
            end
            if (frame_end) begin
              last_d    = 1'b1;
              sending_d = 1'b0;
              slot_d    = '0;
              pix_d     = '0;
              bit_d     = '0;
            end else begin
              slot_d = slot_inc[SW-1:0];
              if (bit_q == BIT_LAST) begin
                bit_d = '0;
                pix_d = pix_q + AW'(1);
              end else begin
                bit_d = bit_q + BIT_CNT_W'(1);
              end
            end
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  // pixel store, read address follows the next pixel position
  lpfs_store #(
    .LED_MAX (LED_MAX),
    .AW      (AW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (store_cmd),
    .wr_addr_i   (idx_ext[AW-1:0]),
    .wr_data_i   (color),
    .fill_last_i (n_m1[AW-1:0]),
    .rd_addr_i   (pix_d),
    .rd_data_o   (pix_word),
    .busy_o      (store_busy)
  );

  // frame state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      slot_q    <= '0;
      pix_q     <= '0;
      bit_q     <= '0;
      done_q    <= 1'b0;
      duty_q    <= '0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
      status_q  <= ST_OK;
    end else begin
      sending_q <= sending_d;
      slot_q    <= slot_d;
      pix_q     <= pix_d;
      bit_q     <= bit_d;
      done_q    <= accept;
      duty_q    <= duty_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
      status_q  <= status_d;
    end
  end

  assign done_o       = done_q;
  assign duty_o       = duty_q;
  assign duty_valid_o = valid_q;
  assign frame_last_o = last_q;
  assign status_o     = status_q;

endmodule

>>> design/lpfs_checker.sv
// ----------------------------------------------------------------------------
// lpfs_checker: port-level checks for the led pixel pwm frame streamer
// watches command and result transactions on the top level ports
// ----------------------------------------------------------------------------
module lpfs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [lpfs_pkg::DUTY_W-1:0] duty_o,
  input logic                        duty_valid_o,
  input logic                        frame_last_o,
  input logic [1:0]                  status_o
);
  import lpfs_pkg::*;

  // every accepted command gives a result in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("no result after accepted command");

  // no result without an accepted command
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result without command");

  // an emitted slot is always an accepted tick
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_valid_o |-> (done_o && (status_o == ST_OK)))
    else $error("slot with wrong status or no strobe");

  // the frame end mark only on an emitted slot
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last_o |-> duty_valid_o)
    else $error("frame end without slot");

  // no duty value on a result without an emitted slot
  a_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !duty_valid_o) |-> (duty_o == '0))
    else $error("duty value without slot");

endmodule

bind led_pixel_pwm_frame_streamer_top lpfs_checker u_lpfs_checker (.*);
